/* rtl/sapm_pkg.sv */
`default_nettype none
package sapm_pkg;
   localparam int unsigned POS_W = 20;
   localparam int unsigned LEN_W = 17;
   localparam int unsigned CNT_W = 21;
   localparam int unsigned CSR_IDX_W = 1;

   typedef enum logic [1:0] {
      MODE_TEXT  = 2'd0,
      MODE_INDEX = 2'd1,
      MODE_QUERY = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEXT_LENGTH = 1'd0,
      CSR_INDEX_COUNT = 1'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_NARROW = 2'd0,
      PH_SINGLE = 2'd1,
      PH_DONE   = 2'd2,
      PH_UNUSED = 2'd3
   } phase_type;

   typedef struct packed {
      logic [1:0]       mode;
      logic [POS_W-1:0] load_address;
      logic [7:0]       text_byte;
      logic [POS_W-1:0] suffix_start;
      logic [7:0]       query_byte;
      logic             query_last;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0] match_position;
      logic [LEN_W-1:0] match_length;
   } rsp_type;
endpackage
`default_nettype wire

/* rtl/sapm_if.sv */
`default_nettype none
interface sapm_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/suffix_array_prefix_match_unit.sv */
// operation: a load item is written to its memory when taken; a query byte in narrowing
// runs two binary searches, each probe an index read then a text read, plus a bound
// correction, and an equality check when the interval closes to one suffix; a
// single-suffix byte does one index read and one text read, a stopped byte neither
// throughput: one item at a time; a result is registered after the last byte's work,
// with an index read of the match position when there is a match, and input waits until it is taken
// reset: synchronous, clears control state, CSRs and query context; datapath registers and memories are not cleared
`default_nettype none
module suffix_array_prefix_match_unit #(
   parameter int unsigned TEXT_DEPTH  = 1048576,
   parameter int unsigned INDEX_DEPTH = 1048576,
   parameter int unsigned QUERY_MAX   = 65536
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   sapm_if.sink                               req,
   sapm_if.source                             rsp,
   input  wire logic                          csr_write_enable,
   input  wire logic [sapm_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [sapm_pkg::CNT_W-1:0]    csr_write_data
);
   import sapm_pkg::*;

   localparam int unsigned TA_W = $clog2(TEXT_DEPTH);
   localparam int unsigned IA_W = $clog2(INDEX_DEPTH);
   localparam int unsigned PW   = (TA_W > CNT_W ? TA_W : CNT_W) + 2;
   localparam int unsigned QO_W = $clog2(QUERY_MAX + 1);
   localparam int unsigned IDX_CAP = (INDEX_DEPTH < (1 << CNT_W)) ? INDEX_DEPTH :
                                     (1 << CNT_W) - 1;

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_START  = 10'b0000000010,
      S_PROBE  = 10'b0000000100,
      S_IWAIT  = 10'b0000001000,
      S_TWAIT  = 10'b0000010000,
      S_DECIDE = 10'b0000100000,
      S_STEP   = 10'b0001000000,
      S_FIN    = 10'b0010000000,
      S_EPOS   = 10'b0100000000,
      S_OUT    = 10'b1000000000
   } state_type;

   // probe kinds
   typedef enum logic [2:0] {
      K_LO   = 3'd0,
      K_HI   = 3'd1,
      K_CORR = 3'd2,
      K_EQ   = 3'd3,
      K_SING = 3'd4,
      K_RES  = 3'd5
   } kind_type;

   logic [7:0]       text_mem [TEXT_DEPTH];
   logic [POS_W-1:0] index_mem [INDEX_DEPTH];

   state_type        state_ff, state_in;
   kind_type         kind_ff, kind_in;
   logic [CNT_W-1:0] tlen_ff, icnt_ff;
   logic [CNT_W-1:0] left_ff, left_in, right_ff, right_in;
   logic [CNT_W-1:0] l_ff, l_in, h_ff, h_in, lo_ff, lo_in;
   logic [CNT_W:0]   hi_ff, hi_in;
   logic [QO_W-1:0]  qoff_ff, qoff_in;
   logic [LEN_W-1:0] cend_ff, cend_in;
   logic             cvalid_ff, cvalid_in;
   phase_type        phase_ff, phase_in;
   logic [7:0]       c_ff, c_in;
   logic             last_ff, last_in;
   logic [CNT_W-1:0] probe_ff, probe_in;
   logic [POS_W-1:0] entry_rd_ff;
   logic             entry_ok_ff;
   logic [7:0]       text_rd_ff;
   logic [PW-1:0]    pos_ff, pos_in;
   logic             ovalid_ff, ovalid_in;
   rsp_type          out_ff, out_in;
   logic             ird_en, trd_en;
   logic [CNT_W-1:0] mid;
   logic [CNT_W-1:0] n_eff;
   logic [7:0]       byte_v;
   logic             past, below;
   logic             acc;

   assign acc       = req.valid && req.ready;
   assign req.ready = state_ff == S_IDLE && !ovalid_ff;
   assign rsp.valid = ovalid_ff;
   assign rsp.payload = out_ff;
   assign mid   = l_ff + ((h_ff - l_ff) >> 1);
   assign n_eff = (icnt_ff > CNT_W'(IDX_CAP)) ? CNT_W'(IDX_CAP) : icnt_ff;

   always_ff @(posedge clock) begin
      if (acc && req.payload.mode == MODE_TEXT && 32'(req.payload.load_address) < TEXT_DEPTH)
         text_mem[TA_W'(req.payload.load_address)] <= req.payload.text_byte;
      if (acc && req.payload.mode == MODE_INDEX &&
            32'(req.payload.load_address) < INDEX_DEPTH)
         index_mem[IA_W'(req.payload.load_address)] <= req.payload.suffix_start;
      if (ird_en) begin
         entry_rd_ff <= index_mem[IA_W'(probe_ff)];
      end
      entry_ok_ff <= 32'(probe_ff) < INDEX_DEPTH;
      if (trd_en) begin
         text_rd_ff <= text_mem[pos_ff[TA_W-1:0]];
      end
   end

   always_comb begin
      past   = pos_ff > PW'(tlen_ff);
      below  = pos_ff < PW'(tlen_ff);
      byte_v = (pos_ff == PW'(tlen_ff) || pos_ff >= PW'(TEXT_DEPTH)) ? 8'd0 : text_rd_ff;
   end

   always_comb begin
      state_in = state_ff; kind_in = kind_ff;
      left_in = left_ff; right_in = right_ff; l_in = l_ff; h_in = h_ff; lo_in = lo_ff;
      hi_in = hi_ff; qoff_in = qoff_ff; cend_in = cend_ff; cvalid_in = cvalid_ff;
      phase_in = phase_ff; c_in = c_ff; last_in = last_ff; probe_in = probe_ff;
      pos_in = pos_ff; ovalid_in = ovalid_ff; out_in = out_ff;
      ird_en = 1'b0; trd_en = 1'b0;
      if (ovalid_ff && rsp.ready) ovalid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (acc && req.payload.mode == MODE_QUERY) begin
               c_in = req.payload.query_byte;
               last_in = req.payload.query_last;
               state_in = S_START;
            end
         end
         S_START: begin
            state_in = S_FIN;
            if (qoff_ff < QO_W'(QUERY_MAX)) begin
               if (qoff_ff == '0) begin
                  left_in = '0;
                  right_in = (n_eff != '0) ? n_eff - 1'b1 : '0;
                  if (n_eff == '0) phase_in = PH_DONE;
                  else phase_in = PH_NARROW;
               end
               state_in = S_STEP;
               kind_in = K_LO;
            end
         end
         S_STEP: begin
            // launch the phase's first action
            state_in = S_FIN;
            if (phase_ff == PH_NARROW) begin
               l_in = left_ff; h_in = right_ff; kind_in = K_LO; state_in = S_PROBE;
            end else if (phase_ff == PH_SINGLE) begin
               probe_in = left_ff; kind_in = K_SING; state_in = S_IWAIT;
            end
            if (state_in != S_FIN || phase_ff == PH_DONE || phase_ff == PH_UNUSED)
               qoff_in = qoff_ff + 1'b1;
         end
         S_PROBE: begin
            if (l_ff < h_ff) begin
               probe_in = mid; state_in = S_IWAIT;
            end else if (kind_ff == K_LO) begin
               lo_in = h_ff; l_in = left_ff; h_in = right_ff; kind_in = K_HI;
            end else begin
               hi_in = {1'b0, h_ff}; probe_in = h_ff; kind_in = K_CORR; state_in = S_IWAIT;
            end
         end
         S_IWAIT: begin
            ird_en = 1'b1;
            state_in = S_EPOS;
         end
         S_EPOS: begin
            pos_in = PW'(entry_ok_ff ? entry_rd_ff : '0) + PW'(qoff_ff - 1'b1);
            if (kind_ff == K_RES) pos_in = PW'(entry_ok_ff ? entry_rd_ff : '0);
            state_in = S_TWAIT;
         end
         S_TWAIT: begin
            trd_en = 1'b1;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = S_PROBE;
            case (kind_ff)
               K_LO: begin
                  if (past || byte_v < c_ff) l_in = probe_ff + 1'b1; else h_in = probe_ff;
               end
               K_HI: begin
                  if (past || byte_v <= c_ff) l_in = probe_ff + 1'b1; else h_in = probe_ff;
               end
               K_CORR: begin
                  if (below && byte_v > c_ff) hi_in = hi_ff - 1'b1;
                  if ((below && byte_v > c_ff ? hi_ff - 1'b1 : hi_ff) == {1'b0, lo_ff}) begin
                     left_in = lo_ff; right_in = lo_ff; probe_in = lo_ff;
                     kind_in = K_EQ; state_in = S_IWAIT;
                  end else if (!hi_ff[CNT_W] && hi_ff != '0 &&
                        (below && byte_v > c_ff ? hi_ff - 1'b1 : hi_ff) > {1'b0, lo_ff}) begin
                     left_in = lo_ff;
                     right_in = (below && byte_v > c_ff) ? hi_ff[CNT_W-1:0] - 1'b1 : hi_ff[CNT_W-1:0];
                     cend_in = LEN_W'(qoff_ff - 1'b1); cvalid_in = 1'b1; state_in = S_FIN;
                  end else if (!hi_ff[CNT_W] && hi_ff != '0 && !(below && byte_v > c_ff) &&
                        hi_ff > {1'b0, lo_ff}) begin
                     state_in = S_FIN;
                  end else begin
                     phase_in = PH_DONE; state_in = S_FIN;
                  end
               end
               K_EQ, K_SING: begin
                  if (below && byte_v == c_ff) begin
                     cend_in = LEN_W'(qoff_ff - 1'b1);
                     if (kind_ff == K_EQ) begin
                        cvalid_in = 1'b1; phase_in = PH_SINGLE;
                     end
                  end else begin
                     phase_in = PH_DONE;
                  end
                  state_in = S_FIN;
               end
               default: begin
                  out_in.match_position = entry_ok_ff ? entry_rd_ff : '0;
                  out_in.match_length = cend_ff + 1'b1;
                  ovalid_in = 1'b1;
                  state_in = S_OUT;
               end
            endcase
         end
         S_FIN: begin
            state_in = S_IDLE;
            if (last_ff) begin
               if (cvalid_ff) begin
                  probe_in = left_ff; kind_in = K_RES; state_in = S_IWAIT;
               end else begin
                  out_in = '0; ovalid_in = 1'b1; state_in = S_OUT;
               end
            end
         end
         S_OUT: begin
            left_in = '0; right_in = '0; qoff_in = '0; cend_in = '0;
            cvalid_in = 1'b0; phase_in = PH_NARROW; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; tlen_ff <= '0; icnt_ff <= '0;
         left_ff <= '0; right_ff <= '0; qoff_ff <= '0; cend_ff <= '0;
         cvalid_ff <= 1'b0; phase_ff <= PH_NARROW; ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; left_ff <= left_in; right_ff <= right_in;
         qoff_ff <= qoff_in; cend_ff <= cend_in; cvalid_ff <= cvalid_in;
         phase_ff <= phase_in; ovalid_ff <= ovalid_in;
         if (csr_write_enable && csr_index == CSR_TEXT_LENGTH) tlen_ff <= csr_write_data;
         if (csr_write_enable && csr_index == CSR_INDEX_COUNT) icnt_ff <= csr_write_data;
      end
      kind_ff <= kind_in; l_ff <= l_in; h_ff <= h_in; lo_ff <= lo_in; hi_ff <= hi_in;
      c_ff <= c_in; last_ff <= last_in; probe_ff <= probe_in; pos_ff <= pos_in;
      out_ff <= out_in;
   end
endmodule
`default_nettype wire

/* rtl/sapm_checker.sv */
`default_nettype none
module sapm_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [sapm_pkg::LEN_W-1:0] rsp_len,
   input wire logic [sapm_pkg::POS_W-1:0] rsp_pos
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_len))
      else $error("result item dropped while stalled");
   a_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("item taken while result waits");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_len == '0 |-> rsp_pos == '0)
      else $error("position without length");
   a_rst: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result after reset");
endmodule

bind suffix_array_prefix_match_unit sapm_checker u_sapm_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_len(rsp.payload.match_length), .rsp_pos(rsp.payload.match_position)
);
`default_nettype wire
